>>> hdl/mfb_pkg.sv
// Shared types, constants and functions for the MAC frame builder.
// No dependencies; imported by every module of the block.
package mfb_pkg;

   localparam int HdrLen     = 30;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int HdrIdxW    = $clog2(HdrLen);

   localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrLen - 1);

   // register indexes
   localparam logic [1:0] CsrFrameMode = 2'd0;
   localparam logic [1:0] CsrSender    = 2'd1;
   localparam logic [1:0] CsrSequence  = 2'd2;

   localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

   localparam logic [7:0] FrameCtlLo = 8'h08;
   localparam logic [7:0] DurationLo = 8'h2E;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] fragment_number;
      logic       last_of_fragment;
      logic       pass_through;
      logic       start;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic        frame_mode;
      logic [15:0] sender_address;
      logic [11:0] sequence_number;
   } cfg_type;

   typedef struct packed {
      logic pop;
      logic idle;
   } back_ctl_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [HdrIdxW-1:0] idx,
                                           input logic [15:0] sender,
                                           input logic [11:0] seq,
                                           input logic [3:0] frag);
      logic [7:0] b;
      case (idx)
         HdrIdxW'(0):  b = FrameCtlLo;
         HdrIdxW'(2):  b = DurationLo;
         HdrIdxW'(8):  b = sender[15:8];
         HdrIdxW'(9):  b = sender[7:0];
         HdrIdxW'(22): b = {seq[3:0], frag};
         HdrIdxW'(23): b = seq[11:4];
         default:      b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

>>> hdl/mac_frame_builder_crc32_core.sv
// Byte-stream 802.11 MAC frame builder with CRC-32 FCS. Top level; depends on
// mfb_pkg, mfb_front, mfb_queue and mfb_back.
//
// With frame_mode at 0 each fragment is wrapped into a frame: 30 header bytes
// ahead of the first payload byte, 4 FCS bytes (least significant first) after
// the last, last_of_frame high on the final FCS byte. With frame_mode at 1
// bytes pass through unchanged and last_of_frame follows last_of_fragment.
// The back-end sequencer emits one byte per cycle while rsp_stall is low and a
// request is queued.
// Requests enter a 4-entry queue and are taken one per cycle
// until it fills; req_stall rises only while the queue is full. csr_ready is
// always high; registers are meant to be written only while the block is idle.
module mac_frame_builder_crc32_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic [3:0]  req_fragment_number,
   input  logic        req_last_of_fragment,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mfb_pkg::*;

   logic         push;
   entry_type    push_entry;
   logic         q_full;
   head_type     head;
   cfg_type      cfg;
   back_ctl_type ctl;

   mfb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_payload_byte     (req_payload_byte),
      .req_fragment_number  (req_fragment_number),
      .req_last_of_fragment (req_last_of_fragment),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .q_full               (q_full),
      .push                 (push),
      .push_entry           (push_entry),
      .cfg                  (cfg)
   );

   mfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (ctl.pop),
      .full       (q_full),
      .head       (head)
   );

   mfb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .cfg               (cfg),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .ctl               (ctl)
   );

   // sequencer never sits mid-request with nothing queued
   a_busy_has_head: assert property (@(posedge clock) disable iff (reset)
      !ctl.idle |-> head.valid)
      else $error("back end busy with empty queue");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> head.valid)
      else $error("pop from empty queue");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");

endmodule

>>> hdl/mfb_front.sv
// Front end: configuration registers, request acceptance and classification.
// Depends on mfb_pkg; feeds mfb_queue.
module mfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_payload_byte,
   input  logic [3:0]          req_fragment_number,
   input  logic                req_last_of_fragment,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                q_full,
   output logic                push,
   output mfb_pkg::entry_type  push_entry,
   output mfb_pkg::cfg_type    cfg
);
   import mfb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    open_ff, open_in;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrFrameMode: cfg_in.frame_mode      = csr_data[0];
            CsrSender:    cfg_in.sender_address  = csr_data;
            CsrSequence:  cfg_in.sequence_number = csr_data[11:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // tag each request as pass-through or as a frame byte, marking the one that opens a frame
   always_comb begin
      push_entry.payload_byte     = req_payload_byte;
      push_entry.fragment_number  = req_fragment_number;
      push_entry.last_of_fragment = req_last_of_fragment;
      push_entry.pass_through     = cfg_ff.frame_mode;
      push_entry.start            = !cfg_ff.frame_mode && !open_ff;
      open_in = open_ff;
      if (push) begin
         open_in = !cfg_ff.frame_mode && !req_last_of_fragment;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> hdl/mfb_queue.sv
// Short request queue between front and back end.
// Depends on mfb_pkg.
module mfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mfb_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output mfb_pkg::head_type  head
);
   import mfb_pkg::*;

   entry_type            mem_ff [QueueDepth];
   logic [QPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]       count_ff, count_in;

   assign full       = count_ff == (QPtrW+1)'(QueueDepth);
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/mfb_back.sv
// Back end: byte sequencer for header, payload and FCS, with the output register.
// Depends on mfb_pkg; drains mfb_queue.
module mfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mfb_pkg::head_type     head,
   input  mfb_pkg::cfg_type      cfg,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_last_of_frame,
   output mfb_pkg::back_ctl_type ctl
);
   import mfb_pkg::*;

   typedef enum logic [1:0] {ST_NEXT, ST_HDR, ST_PAY, ST_FCS} state_type;

   state_type            st_ff, st_in;
   logic [HdrIdxW-1:0]   cnt_ff, cnt_in;
   logic [31:0]          crc_ff, crc_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 slot_free;
   logic                 pop;
   logic                 do_pay;
   logic [31:0]          fcs;

   assign slot_free         = !valid_ff || !rsp_stall;
   assign rsp_valid         = valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_last_of_frame = last_ff;
   assign ctl.pop           = pop;
   assign ctl.idle          = st_ff == ST_NEXT;
   assign fcs               = ~crc_ff;

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      valid_in = 1'b0;
      byte_in  = byte_ff;
      last_in  = 1'b0;
      pop      = 1'b0;
      do_pay   = 1'b0;
      if (slot_free && head.valid) begin
         valid_in = 1'b1;
         unique case (st_ff)
            ST_NEXT: begin
               if (head.entry.pass_through) begin
                  byte_in = head.entry.payload_byte;
                  last_in = head.entry.last_of_fragment;
                  crc_in  = CrcInit;
                  pop     = 1'b1;
               end else if (head.entry.start) begin
                  byte_in = hdr_byte('0, cfg.sender_address, cfg.sequence_number,
                                     head.entry.fragment_number);
                  crc_in  = crc_byte(CrcInit, byte_in);
                  cnt_in  = HdrIdxW'(1);
                  st_in   = ST_HDR;
               end else begin
                  do_pay = 1'b1;
               end
            end
            ST_HDR: begin
               byte_in = hdr_byte(cnt_ff, cfg.sender_address, cfg.sequence_number,
                                  head.entry.fragment_number);
               crc_in  = crc_byte(crc_ff, byte_in);
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == HdrLastIdx) begin
                  st_in = ST_PAY;
               end
            end
            ST_PAY: do_pay = 1'b1;
            ST_FCS: begin
               byte_in = fcs[{cnt_ff[1:0], 3'b000} +: 8];
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff[1:0] == 2'd3) begin
                  last_in = 1'b1;
                  crc_in  = CrcInit;
                  pop     = 1'b1;
                  st_in   = ST_NEXT;
               end
            end
            default: st_in = ST_NEXT;
         endcase
         if (do_pay) begin
            byte_in = head.entry.payload_byte;
            crc_in  = crc_byte(crc_ff, byte_in);
            if (head.entry.last_of_fragment) begin
               cnt_in = '0;
               st_in  = ST_FCS;
            end else begin
               pop   = 1'b1;
               st_in = ST_NEXT;
            end
         end
      end else if (!slot_free) begin
         // hold the waiting byte
         valid_in = valid_ff;
         last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_NEXT;
         cnt_ff   <= '0;
         crc_ff   <= CrcInit;
         valid_ff <= 1'b0;
         byte_ff  <= 8'd0;
         last_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
      end
   end

endmodule

>>> tb/tb.sv
// Testbench for mac_frame_builder_crc32_core: directed and random fragment traffic, checked
// byte by byte against a local frame and CRC-32 predictor. Depends on mfb_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

   localparam int          FrameHdrBytes = 30;
   localparam logic [7:0]  FrameCtlByte  = 8'h08;
   localparam logic [7:0]  DurationByte  = 8'h2E;
   localparam logic [31:0] Crc32Seed     = 32'hFFFF_FFFF;
   localparam logic [31:0] Crc32Poly     = 32'hEDB8_8320;
   localparam logic [1:0]  CsrUnused     = 2'd3;
   localparam int          DrainCycles   = 8;
   localparam int          MaxReported   = 10;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } frame_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_payload_byte = 8'h00;
   logic [3:0]  req_fragment_number = 4'h0;
   logic        req_last_of_fragment = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_of_frame;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'h0000;

   // frame builder state as the testbench sees it
   logic        pass_mode = 1'b0;
   logic [15:0] sender_id = 16'h0000;
   logic [11:0] seq_num = 12'h000;
   logic [31:0] crc_acc = Crc32Seed;
   logic        frame_in_progress = 1'b0;

   frame_out_type pending_frame_bytes[$];
   int unsigned   mismatch_count = 0;

   logic        req_gaps_on = 1'b1;
   logic        rsp_gaps_on = 1'b1;
   int unsigned rsp_hold_request = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_wait = 0;

   mac_frame_builder_crc32_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_payload_byte     (req_payload_byte),
      .req_fragment_number  (req_fragment_number),
      .req_last_of_fragment (req_last_of_fragment),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_last_of_frame    (rsp_last_of_frame),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[0] ^ data[i];
         acc = {1'b0, acc[31:1]} ^ (feedback ? Crc32Poly : 32'h0);
      end
      return acc;
   endfunction

   task automatic push_expected(input logic [7:0] data, input logic last);
      frame_out_type item;
      item.frame_byte    = data;
      item.last_of_frame = last;
      pending_frame_bytes.insert(pending_frame_bytes.size(), item);
   endtask

   task automatic push_framed_byte(input logic [7:0] data);
      push_expected(data, 1'b0);
      crc_acc = crc32_update(crc_acc, data);
   endtask

   task automatic predict_frame_bytes(input logic [7:0] data, input logic [3:0] frag,
                                      input logic last);
      logic [7:0]  hdr [FrameHdrBytes];
      logic [15:0] seq_word;
      logic [31:0] fcs;
      if (pass_mode) begin
         // drop any open frame
         frame_in_progress = 1'b0;
         crc_acc = Crc32Seed;
         push_expected(data, last);
         return;
      end
      if (!frame_in_progress) begin
         seq_word = {seq_num, frag};
         foreach (hdr[i]) hdr[i] = 8'h00;
         hdr[0]  = FrameCtlByte;
         hdr[2]  = DurationByte;
         hdr[8]  = sender_id[15:8];
         hdr[9]  = sender_id[7:0];
         hdr[22] = seq_word[7:0];
         hdr[23] = seq_word[15:8];
         crc_acc = Crc32Seed;
         foreach (hdr[i]) push_framed_byte(hdr[i]);
         frame_in_progress = 1'b1;
      end
      push_framed_byte(data);
      if (last) begin
         fcs = ~crc_acc;
         for (int k = 0; k < 4; k++) push_expected(fcs[8*k +: 8], k == 3);
         crc_acc = Crc32Seed;
         frame_in_progress = 1'b0;
      end
   endtask

   // Called at a rising edge; returns at the edge that accepts the request.
   task automatic send_payload_byte(input logic [7:0] data, input logic [3:0] frag,
                                    input logic last);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_frame_bytes(data, frag, last);
      req_valid            <= 1'b1;
      req_payload_byte     <= data;
      req_fragment_number  <= frag;
      req_last_of_fragment <= last;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid === 1'b1 && csr_ready === 1'b1));
      case (index)
         mfb_pkg::CsrFrameMode: pass_mode = data[0];
         mfb_pkg::CsrSender:    sender_id = data;
         mfb_pkg::CsrSequence:  seq_num = data[11:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input frame_out_type want);
      if (mismatch_count < MaxReported)
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime,
                  what, want.frame_byte, want.last_of_frame, rsp_frame_byte, rsp_last_of_frame);
      mismatch_count++;
   endtask

   // receiver: random stall per result, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_hold_request != 0) begin
            rsp_hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            rsp_wait = rsp_gaps_on ? $urandom_range(0, 12) : 0;
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_frame_bytes.size() == 0) begin
            want = '0;
            report_mismatch("unexpected byte", want);
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_frame_byte !== want.frame_byte || rsp_last_of_frame !== want.last_of_frame)
               report_mismatch("byte mismatch", want);
         end
      end
   end

   task automatic test_reset_defaults();
      // frame mode, sender and sequence all at their reset values
      send_payload_byte(8'h5A, 4'h3, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_header_extremes();
      write_csr(mfb_pkg::CsrSender, 16'hFFFF);
      write_csr(mfb_pkg::CsrSequence, 16'hFFFF);
      write_csr(mfb_pkg::CsrFrameMode, 16'hFFFE);
      send_payload_byte(8'hFF, 4'hF, 1'b1);
      send_payload_byte(8'h00, 4'h0, 1'b0);
      send_payload_byte(8'hAA, 4'hF, 1'b0);
      send_payload_byte(8'h55, 4'h0, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_pass_through();
      // leave a frame open, then abandon it in pass-through mode
      send_payload_byte(8'h3C, 4'h9, 1'b0);
      wait_for_drain();
      write_csr(mfb_pkg::CsrFrameMode, 16'h0001);
      send_payload_byte(8'h00, 4'h0, 1'b0);
      send_payload_byte(8'hFF, 4'hF, 1'b1);
      send_payload_byte(8'h81, 4'h5, 1'b1);
      send_payload_byte(8'h7E, 4'hA, 1'b0);
      wait_for_drain();
      write_csr(mfb_pkg::CsrFrameMode, 16'h0000);
      send_payload_byte(8'hC3, 4'h6, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_unused_index();
      write_csr(CsrUnused, 16'hFFFF);
      send_payload_byte(8'h12, 4'h4, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_writes_during_frame();
      send_payload_byte(8'hA5, 4'h2, 1'b0);
      wait_for_drain();
      // header is already out; these only affect the next frame
      write_csr(mfb_pkg::CsrSender, 16'h1234);
      write_csr(mfb_pkg::CsrSequence, 16'h0ABC);
      write_csr(mfb_pkg::CsrFrameMode, 16'h0001);
      write_csr(mfb_pkg::CsrFrameMode, 16'h0000);
      send_payload_byte(8'h5A, 4'h7, 1'b1);
      wait_for_drain();
      send_payload_byte(8'h01, 4'h1, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      int unsigned len;
      int unsigned sent;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      write_csr(mfb_pkg::CsrFrameMode, 16'h0000);
      // hold the receiver so the block fills up and stalls requests
      rsp_hold_request = 200;
      sent = 0;
      while (sent < 24) begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++)
            send_payload_byte(8'($urandom), 4'($urandom), i == len - 1);
         sent += len;
      end
      wait_for_drain();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_random_frames(input int unsigned item_budget);
      int unsigned sent;
      int unsigned phase_end;
      int unsigned len;
      logic        broken;
      logic [15:0] value;
      sent = 0;
      while (sent < item_budget) begin
         value = 16'($urandom);
         value[0] = ($urandom_range(0, 3) == 0);
         write_csr(mfb_pkg::CsrFrameMode, value);
         case ($urandom_range(0, 3))
            0:       value = 16'h0000;
            1:       value = 16'hFFFF;
            default: value = 16'($urandom);
         endcase
         write_csr(mfb_pkg::CsrSender, value);
         value = 16'($urandom);
         case ($urandom_range(0, 3))
            0:       value[11:0] = 12'h000;
            1:       value[11:0] = 12'hFFF;
            default: ;
         endcase
         write_csr(mfb_pkg::CsrSequence, value);
         if ($urandom_range(0, 3) == 0) write_csr(CsrUnused, 16'($urandom));
         req_gaps_on = ($urandom_range(0, 2) != 0);
         rsp_gaps_on = ($urandom_range(0, 2) != 0);
         phase_end = sent + $urandom_range(20, 45);
         while (sent < phase_end && sent < item_budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            // now and then leave the fragment open into the next one
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++)
               send_payload_byte(8'($urandom), 4'($urandom), (i == len - 1) && !broken);
            sent += len;
         end
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_header_extremes();
      test_pass_through();
      test_unused_index();
      test_writes_during_frame();
      test_backpressure();
      test_random_frames(270);
      wait_for_drain();
      if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
hdl/mfb_pkg.sv
hdl/mfb_front.sv
hdl/mfb_queue.sv
hdl/mfb_back.sv
hdl/mac_frame_builder_crc32_core.sv
tb/tb.sv
